// ===== hw/rtl/mmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared types, codes and byte tables of the MIDI message framer.
// ----------------------------------------------------------------------------
package mmf_pkg;

  // command codes on cmd_i
  localparam logic [3:0] CMD_NOTE_ON  = 4'd0;
  localparam logic [3:0] CMD_NOTE_OFF = 4'd1;
  localparam logic [3:0] CMD_CTRL     = 4'd2;
  localparam logic [3:0] CMD_PROGRAM  = 4'd3;
  localparam logic [3:0] CMD_PRESSURE = 4'd4;
  localparam logic [3:0] CMD_BEND     = 4'd5;
  localparam logic [3:0] CMD_RPN      = 4'd6;
  localparam logic [3:0] CMD_NRPN     = 4'd7;
  localparam logic [3:0] CMD_GS       = 4'd8;

  // status bases
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_CTRL     = 8'hB0;
  localparam logic [7:0] ST_PROGRAM  = 8'hC0;
  localparam logic [7:0] ST_PRESSURE = 8'hD0;
  localparam logic [7:0] ST_BEND     = 8'hE0;

  // controller numbers for parameter messages
  localparam logic [7:0] CC_RPN_MSB    = 8'd101;
  localparam logic [7:0] CC_RPN_LSB    = 8'd100;
  localparam logic [7:0] CC_NRPN_MSB   = 8'd99;
  localparam logic [7:0] CC_NRPN_LSB   = 8'd98;
  localparam logic [7:0] CC_DATA_ENTRY = 8'd6;
  localparam logic [7:0] CC_NULL       = 8'h7F;

  // sysex framing
  localparam logic [7:0] SX_START  = 8'hF0;
  localparam logic [7:0] SX_END    = 8'hF7;
  localparam logic [7:0] GS_MAKER  = 8'h41;
  localparam logic [7:0] GS_DEVICE = 8'h10;
  localparam logic [7:0] GS_MODEL  = 8'h42;
  localparam logic [7:0] GS_DT1    = 8'h12;

  // bend offset and limit
  localparam logic signed [16:0] BEND_CENTRE = 17'sd8192;
  localparam logic [13:0]        BEND_MAX    = 14'h3FFF;

  // message lengths
  localparam int MAX_MSG_LEN = 15;
  localparam int IDX_W       = $clog2(MAX_MSG_LEN);
  localparam logic [IDX_W-1:0] LAST_VOICE3 = IDX_W'(2);
  localparam logic [IDX_W-1:0] LAST_VOICE2 = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_PARAM  = IDX_W'(14);
  localparam logic [IDX_W-1:0] LAST_SYSEX  = IDX_W'(10);

  // default depth of the message queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MSG_VOICE,
    MSG_PARAM,
    MSG_SYSEX
  } msg_kind_e;

  // one classified message waiting for the sequencer
  typedef struct packed {
    msg_kind_e        kind;
    logic [IDX_W-1:0] last_idx;
    logic             nrpn;
    logic [7:0]       status;
    logic [6:0]       d0;
    logic [6:0]       d1;
    logic [6:0]       d2;
    logic [7:0]       addr_hi;
    logic [7:0]       addr_mid;
    logic [7:0]       addr_lo;
  } mmf_desc_t;

  // byte number idx of a message
  function automatic logic [7:0] mmf_byte_at(mmf_desc_t d, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    logic [7:0] num_hi;
    logic [7:0] num_lo;
    b      = d.status;
    num_hi = d.nrpn ? CC_NRPN_MSB : CC_RPN_MSB;
    num_lo = d.nrpn ? CC_NRPN_LSB : CC_RPN_LSB;
    case (d.kind)
      MSG_VOICE: begin
        case (idx)
          IDX_W'(0): b = d.status;
          IDX_W'(1): b = {1'b0, d.d0};
          default:   b = {1'b0, d.d1};
        endcase
      end
      MSG_PARAM: begin
        case (idx)
          IDX_W'(1), IDX_W'(10):  b = num_hi;
          IDX_W'(4), IDX_W'(13):  b = num_lo;
          IDX_W'(2):              b = {1'b0, d.d0};
          IDX_W'(5):              b = {1'b0, d.d1};
          IDX_W'(7):              b = CC_DATA_ENTRY;
          IDX_W'(8):              b = {1'b0, d.d2};
          IDX_W'(11), IDX_W'(14): b = CC_NULL;
          default:                b = d.status;
        endcase
      end
      MSG_SYSEX: begin
        case (idx)
          IDX_W'(0): b = SX_START;
          IDX_W'(1): b = GS_MAKER;
          IDX_W'(2): b = GS_DEVICE;
          IDX_W'(3): b = GS_MODEL;
          IDX_W'(4): b = GS_DT1;
          IDX_W'(5): b = d.addr_hi;
          IDX_W'(6): b = d.addr_mid;
          IDX_W'(7): b = d.addr_lo;
          IDX_W'(8): b = {1'b0, d.d0};
          IDX_W'(9): b = {1'b0, d.d1};
          default:   b = SX_END;
        endcase
      end
      default: b = d.status;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/mmf_front.sv =====
// ----------------------------------------------------------------------------
// mmf_front
// Classifies a command word into a message descriptor: clamps, bend, checksum.
// ----------------------------------------------------------------------------
module mmf_front (
  input  logic              push_i,
  input  logic              full_i,
  input  logic [3:0]        cmd_i,
  input  logic [7:0]        channel_i,
  input  logic [7:0]        key_i,
  input  logic [7:0]        value_i,
  input  logic [7:0]        param_lsb_i,
  input  logic signed [15:0] bend_i,
  input  logic [7:0]        gs_addr_hi_i,
  input  logic [7:0]        gs_addr_mid_i,
  input  logic [7:0]        gs_addr_lo_i,
  output logic              wr_o,
  output mmf_pkg::mmf_desc_t desc_o
);

  function automatic logic [6:0] clamp7(logic [7:0] v);
    return v[7] ? 7'h7F : v[6:0];
  endfunction

  logic [3:0]        chan_nib;
  logic signed [16:0] bend_sum;
  logic [13:0]       bend_val;
  logic [6:0]        gs_data;
  logic [6:0]        gs_sum;
  logic              known;

  // channel clamped to 1..16, minus one
  always_comb begin
    if (channel_i == 8'd0) begin
      chan_nib = 4'd0;
    end else if (channel_i > 8'd16) begin
      chan_nib = 4'd15;
    end else begin
      chan_nib = 4'(channel_i - 8'd1);
    end
  end

  // bend offset and clamp to 14 bits
  always_comb begin
    bend_sum = 17'(signed'({bend_i[15], bend_i})) + mmf_pkg::BEND_CENTRE;
    if (bend_sum[16]) begin
      bend_val = '0;
    end else if (bend_sum[15:14] != 2'b00) begin
      bend_val = mmf_pkg::BEND_MAX;
    end else begin
      bend_val = bend_sum[13:0];
    end
  end

  // gs checksum, all modulo 128
  assign gs_data = value_i[6:0];
  assign gs_sum  = gs_addr_hi_i[6:0] + gs_addr_mid_i[6:0] + gs_addr_lo_i[6:0] + gs_data;

  // command decode
  always_comb begin
    known           = 1'b1;
    desc_o          = '0;
    desc_o.kind     = mmf_pkg::MSG_VOICE;
    desc_o.last_idx = mmf_pkg::LAST_VOICE3;
    desc_o.d0       = clamp7(key_i);
    desc_o.d1       = clamp7(value_i);
    desc_o.d2       = clamp7(value_i);
    desc_o.addr_hi  = gs_addr_hi_i;
    desc_o.addr_mid = gs_addr_mid_i;
    desc_o.addr_lo  = gs_addr_lo_i;
    desc_o.status   = mmf_pkg::ST_CTRL | {4'd0, chan_nib};
    case (cmd_i)
      mmf_pkg::CMD_NOTE_ON: begin
        desc_o.status = mmf_pkg::ST_NOTE_ON | {4'd0, chan_nib};
      end
      mmf_pkg::CMD_NOTE_OFF: begin
        desc_o.status = mmf_pkg::ST_NOTE_OFF | {4'd0, chan_nib};
        desc_o.d1     = 7'h40;
      end
      mmf_pkg::CMD_CTRL: begin
        desc_o.status = mmf_pkg::ST_CTRL | {4'd0, chan_nib};
      end
      mmf_pkg::CMD_PROGRAM: begin
        desc_o.status   = mmf_pkg::ST_PROGRAM | {4'd0, chan_nib};
        desc_o.last_idx = mmf_pkg::LAST_VOICE2;
      end
      mmf_pkg::CMD_PRESSURE: begin
        desc_o.status   = mmf_pkg::ST_PRESSURE | {4'd0, chan_nib};
        desc_o.last_idx = mmf_pkg::LAST_VOICE2;
      end
      mmf_pkg::CMD_BEND: begin
        desc_o.status = mmf_pkg::ST_BEND | {4'd0, chan_nib};
        desc_o.d0     = bend_val[6:0];
        desc_o.d1     = bend_val[13:7];
      end
      mmf_pkg::CMD_RPN, mmf_pkg::CMD_NRPN: begin
        desc_o.kind     = mmf_pkg::MSG_PARAM;
        desc_o.last_idx = mmf_pkg::LAST_PARAM;
        desc_o.nrpn     = (cmd_i == mmf_pkg::CMD_NRPN);
        desc_o.d1       = clamp7(param_lsb_i);
      end
      mmf_pkg::CMD_GS: begin
        desc_o.kind     = mmf_pkg::MSG_SYSEX;
        desc_o.last_idx = mmf_pkg::LAST_SYSEX;
        desc_o.d0       = gs_data;
        desc_o.d1       = 7'(7'd0 - gs_sum);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown commands are taken and dropped
  assign wr_o = push_i && !full_i && known;

endmodule

// ===== hw/rtl/mmf_queue.sv =====
// ----------------------------------------------------------------------------
// mmf_queue
// Short descriptor queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module mmf_queue #(
  parameter int Depth = mmf_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  mmf_pkg::mmf_desc_t wr_desc_i,
  input  logic               rd_i,
  output mmf_pkg::mmf_desc_t rd_desc_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mmf_pkg::mmf_desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign rd_desc_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

  // occupancy never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("queue count above depth");

  // a lone write grows the queue by one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !rd_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count lost a write");

endmodule

// ===== hw/rtl/mmf_back.sv =====
// ----------------------------------------------------------------------------
// mmf_back
// Byte sequencer: walks the head descriptor and fills a two-entry output buffer.
// ----------------------------------------------------------------------------
module mmf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmf_pkg::mmf_desc_t head_i,
  input  logic               head_empty_i,
  output logic               head_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);

  localparam logic [1:0] OutFull = 2'd2;

  logic [mmf_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [7:0] ob_byte_q [2];
  logic       ob_last_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       emit;
  logic       at_last;
  logic       take;

  assign emit       = !head_empty_i && (cnt_q != OutFull);
  assign at_last    = (idx_q == head_i.last_idx);
  assign head_pop_o = emit && at_last;
  assign take       = pop_i && (cnt_q != 2'd0);

  // byte index within the current message
  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = at_last ? '0 : idx_q + mmf_pkg::IDX_W'(1);
    end
  end

  // output buffer occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (emit && !take) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!emit && take) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      if (emit) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (take) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // output buffer data
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_byte_q[wr_ptr_q] <= mmf_pkg::mmf_byte_at(head_i, idx_q);
      ob_last_q[wr_ptr_q] <= at_last;
    end
  end

  assign empty_o    = (cnt_q == 2'd0);
  assign out_byte_o = ob_byte_q[rd_ptr_q];
  assign last_o     = ob_last_q[rd_ptr_q];

  // the index stays inside the current message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> (idx_q <= head_i.last_idx))
    else $error("byte index beyond message end");

  // with no message waiting the sequencer sits at the first byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_empty_i |-> (idx_q == '0))
    else $error("byte index not rewound between messages");

endmodule

// ===== hw/rtl/midi_message_framer_core.sv =====
// ----------------------------------------------------------------------------
// midi_message_framer_core
// Turns MIDI command words into wire bytes, with last set on each final byte.
// ----------------------------------------------------------------------------
// A taken word enters the descriptor queue; the sequencer registers its bytes into
// the output buffer at one byte per cycle while a message waits and the buffer has
// room. Words give 2, 3, 11 or 15 bytes; unknown commands are taken and give none.
// The descriptor queue lets new words in while the sequencer is busy.
// Reset clears queue and output buffer pointers; no clearing pass.
module midi_message_framer_core #(
  parameter int QueueDepth = mmf_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         cmd_i,
  input  logic [7:0]         channel_i,
  input  logic [7:0]         key_i,
  input  logic [7:0]         value_i,
  input  logic [7:0]         param_lsb_i,
  input  logic signed [15:0] bend_i,
  input  logic [7:0]         gs_addr_hi_i,
  input  logic [7:0]         gs_addr_mid_i,
  input  logic [7:0]         gs_addr_lo_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);

  logic               q_wr;
  mmf_pkg::mmf_desc_t q_wr_desc;
  logic               q_rd;
  mmf_pkg::mmf_desc_t q_head;
  logic               q_empty;

  // classifier
  mmf_front u_front (
    .push_i        (push),
    .full_i        (full),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .param_lsb_i   (param_lsb_i),
    .bend_i        (bend_i),
    .gs_addr_hi_i  (gs_addr_hi_i),
    .gs_addr_mid_i (gs_addr_mid_i),
    .gs_addr_lo_i  (gs_addr_lo_i),
    .wr_o          (q_wr),
    .desc_o        (q_wr_desc)
  );

  // descriptor queue
  mmf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_desc_i (q_wr_desc),
    .rd_i      (q_rd),
    .rd_desc_o (q_head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  // byte sequencer and output buffer
  mmf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_empty_i (q_empty),
    .head_pop_o   (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

// ===== sim/midi_message_framer_core_tb.sv =====
// ----------------------------------------------------------------------------
// midi_message_framer_core_tb
// Self-checking bench for the MIDI message framer: a directed table of
// command words (extremes, every command, unknown codes) followed by random
// words under three idling mixes. Every byte popped from the block is checked
// against a byte-level prediction of the wire stream.
// ----------------------------------------------------------------------------
module midi_message_framer_core_tb;

  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_WORDS  = 140;
  localparam int PRED         = -1;

  // one command word as pushed into the block
  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  channel;
    logic [7:0]  key;
    logic [7:0]  value;
    logic [7:0]  param_lsb;
    logic [15:0] bend;
    logic [7:0]  gs_addr_hi;
    logic [7:0]  gs_addr_mid;
    logic [7:0]  gs_addr_lo;
  } cmd_word_t;

  // one byte on the wire
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } wire_byte_t;

  // directed row: a word plus, for the obvious cases, its bytes typed in
  typedef struct packed {
    cmd_word_t   word;
    logic        use_pred;
    logic [1:0]  n;
    logic [23:0] bytes;
  } dir_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              push          = 1'b0;
  logic              full;
  logic [3:0]        cmd_i         = '0;
  logic [7:0]        channel_i     = '0;
  logic [7:0]        key_i         = '0;
  logic [7:0]        value_i       = '0;
  logic [7:0]        param_lsb_i   = '0;
  logic signed [15:0] bend_i       = '0;
  logic [7:0]        gs_addr_hi_i  = '0;
  logic [7:0]        gs_addr_mid_i = '0;
  logic [7:0]        gs_addr_lo_i  = '0;
  logic              empty;
  logic              pop           = 1'b0;
  logic [7:0]        out_byte_o;
  logic              last_o;

  wire_byte_t wire_bytes_q [$];
  dir_row_t   dir_table [$];
  int         mismatches    = 0;
  int         stall_cycles  = 0;
  int         send_idle_pct = 32;
  int         recv_idle_pct = 55;

  midi_message_framer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .param_lsb_i   (param_lsb_i),
    .bend_i        (bend_i),
    .gs_addr_hi_i  (gs_addr_hi_i),
    .gs_addr_mid_i (gs_addr_mid_i),
    .gs_addr_lo_i  (gs_addr_lo_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // data byte limit
  function automatic logic [7:0] clip7(input logic [7:0] v);
    return (v > 8'd127) ? 8'd127 : v;
  endfunction

  // status byte with the channel held to 1..16
  function automatic logic [7:0] status_byte(input logic [7:0] base, input logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (c < 8'd1) c = 8'd1;
    if (c > 8'd16) c = 8'd16;
    return base | (c - 8'd1);
  endfunction

  // expected wire bytes of one command word, queued in order
  function automatic void frame_command(input cmd_word_t w);
    logic [7:0] msg [$];
    logic [7:0] st_cc;
    logic [7:0] num_hi;
    logic [7:0] num_lo;
    logic [6:0] d;
    logic [6:0] sum7;
    int         v;
    wire_byte_t wb;
    st_cc  = status_byte(mmf_pkg::ST_CTRL, w.channel);
    num_hi = (w.cmd == mmf_pkg::CMD_NRPN) ? mmf_pkg::CC_NRPN_MSB : mmf_pkg::CC_RPN_MSB;
    num_lo = (w.cmd == mmf_pkg::CMD_NRPN) ? mmf_pkg::CC_NRPN_LSB : mmf_pkg::CC_RPN_LSB;
    case (w.cmd)
      mmf_pkg::CMD_NOTE_ON: begin
        msg = '{status_byte(mmf_pkg::ST_NOTE_ON, w.channel), clip7(w.key),
                clip7(w.value)};
      end
      mmf_pkg::CMD_NOTE_OFF: begin
        msg = '{status_byte(mmf_pkg::ST_NOTE_OFF, w.channel), clip7(w.key), 8'h40};
      end
      mmf_pkg::CMD_CTRL: begin
        msg = '{st_cc, clip7(w.key), clip7(w.value)};
      end
      mmf_pkg::CMD_PROGRAM: begin
        msg = '{status_byte(mmf_pkg::ST_PROGRAM, w.channel), clip7(w.key)};
      end
      mmf_pkg::CMD_PRESSURE: begin
        msg = '{status_byte(mmf_pkg::ST_PRESSURE, w.channel), clip7(w.key)};
      end
      mmf_pkg::CMD_BEND: begin
        v = $signed(w.bend) + 8192;
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        msg = '{status_byte(mmf_pkg::ST_BEND, w.channel), {1'b0, v[6:0]},
                {1'b0, v[13:7]}};
      end
      mmf_pkg::CMD_RPN, mmf_pkg::CMD_NRPN: begin
        msg = '{st_cc, num_hi, clip7(w.key),
                st_cc, num_lo, clip7(w.param_lsb),
                st_cc, mmf_pkg::CC_DATA_ENTRY, clip7(w.value),
                st_cc, num_hi, mmf_pkg::CC_NULL,
                st_cc, num_lo, mmf_pkg::CC_NULL};
      end
      mmf_pkg::CMD_GS: begin
        d    = w.value[6:0];
        sum7 = 7'(w.gs_addr_hi + w.gs_addr_mid + w.gs_addr_lo + d);
        msg  = '{mmf_pkg::SX_START, mmf_pkg::GS_MAKER, mmf_pkg::GS_DEVICE,
                 mmf_pkg::GS_MODEL, mmf_pkg::GS_DT1,
                 w.gs_addr_hi, w.gs_addr_mid, w.gs_addr_lo, {1'b0, d},
                 {1'b0, 7'(8'd128 - {1'b0, sum7})}, mmf_pkg::SX_END};
      end
      default: ;
    endcase
    foreach (msg[i]) begin
      wb.out_byte = msg[i];
      wb.last     = (i == msg.size() - 1);
      wire_bytes_q.push_back(wb);
    end
  endfunction

  // build one directed row
  function automatic dir_row_t row(input logic [3:0] c, input int ch,
                                   input int k, input int v,
                                   input int lsb, input int b,
                                   input logic [23:0] addr, input int n,
                                   input logic [23:0] exp_bytes);
    dir_row_t r;
    r.word     = '{c, 8'(ch), 8'(k), 8'(v), 8'(lsb), 16'(b),
                   addr[23:16], addr[15:8], addr[7:0]};
    r.use_pred = (n < 0);
    r.n        = (n < 0) ? 2'd0 : 2'(n);
    r.bytes    = exp_bytes;
    return r;
  endfunction

  // random 8-bit field, often kept in the data range
  function automatic logic [7:0] rand_byte();
    return ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
  endfunction

  // random command word, with a few unknown codes
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    int        b;
    w.cmd = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    w.channel     = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(17));
    w.key         = rand_byte();
    w.value       = rand_byte();
    w.param_lsb   = rand_byte();
    w.gs_addr_hi  = 8'($urandom_range(255));
    w.gs_addr_mid = 8'($urandom_range(255));
    w.gs_addr_lo  = 8'($urandom_range(255));
    case ($urandom_range(2))
      0:       b = $urandom_range(65535);
      1:       b = $urandom_range(16600) - 8300;
      default: b = ($urandom_range(1) == 0) ? $urandom_range(8200, 8184)
                                            : -$urandom_range(8200, 8184);
    endcase
    w.bend = 16'(b);
    return w;
  endfunction

  // drive one word and wait for it to be taken
  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    cmd_i         <= w.cmd;
    channel_i     <= w.channel;
    key_i         <= w.key;
    value_i       <= w.value;
    param_lsb_i   <= w.param_lsb;
    bend_i        <= w.bend;
    gs_addr_hi_i  <= w.gs_addr_hi;
    gs_addr_mid_i <= w.gs_addr_mid;
    gs_addr_lo_i  <= w.gs_addr_lo;
    do @(posedge clk_i); while (full);
  endtask

  // hold the sender until every expected byte has come out
  task automatic drain_expected();
    push <= 1'b0;
    @(posedge clk_i);
    while (wire_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: check each popped byte against the oldest expectation
  always @(posedge clk_i) begin
    wire_byte_t exp_b;
    if (rst_ni && pop && !empty) begin
      if (wire_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, out_byte_o, last_o);
        mismatches++;
      end else begin
        exp_b = wire_bytes_q.pop_front();
        if (out_byte_o !== exp_b.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, exp_b.out_byte, out_byte_o);
          mismatches++;
        end
        if (last_o !== exp_b.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_b.last, last_o);
          mismatches++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word moved on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** midi_message_framer_core: FAILED **");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t   r;
    wire_byte_t wb;
    // extremes and every command; bytes typed in where obvious
    dir_table.push_back(row(mmf_pkg::CMD_NOTE_ON, 0, 255, 255, 0, 0, 24'h0, 3, 24'h907F7F));
    dir_table.push_back(row(mmf_pkg::CMD_NOTE_ON, 1, 0, 0, 0, 0, 24'h0, 3, 24'h900000));
    dir_table.push_back(row(mmf_pkg::CMD_NOTE_OFF, 255, 200, 3, 0, 0, 24'h0, 3, 24'h8F7F40));
    dir_table.push_back(row(mmf_pkg::CMD_NOTE_OFF, 16, 127, 127, 0, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_CTRL, 5, 128, 127, 0, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_CTRL, 17, 7, 0, 0, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_PROGRAM, 16, 255, 0, 0, 0, 24'h0, 2, 24'hCF7F));
    dir_table.push_back(row(mmf_pkg::CMD_PRESSURE, 17, 0, 0, 0, 0, 24'h0, 2, 24'hDF00));
    dir_table.push_back(row(mmf_pkg::CMD_PRESSURE, 2, 128, 9, 0, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_BEND, 1, 0, 0, 0, -32768, 24'h0, 3, 24'hE00000));
    dir_table.push_back(row(mmf_pkg::CMD_BEND, 1, 0, 0, 0, 32767, 24'h0, 3, 24'hE07F7F));
    dir_table.push_back(row(mmf_pkg::CMD_BEND, 1, 0, 0, 0, 0, 24'h0, 3, 24'hE00040));
    dir_table.push_back(row(mmf_pkg::CMD_BEND, 3, 0, 0, 0, -8192, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_BEND, 3, 0, 0, 0, 8191, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_BEND, 10, 0, 0, 0, -1, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_RPN, 1, 0, 0, 0, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_RPN, 200, 255, 255, 255, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_NRPN, 16, 127, 128, 1, 0, 24'h0, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_NRPN, 0, 5, 9, 200, 0, 24'h0, PRED, 24'h0));
    // checksum wrapping to zero, all-ones address, data masked to zero
    dir_table.push_back(row(mmf_pkg::CMD_GS, 1, 0, 0, 0, 0, 24'h400040, PRED, 24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_GS, 255, 255, 255, 255, -1, 24'hFFFFFF, PRED,
                            24'h0));
    dir_table.push_back(row(mmf_pkg::CMD_GS, 1, 0, 128, 0, 0, 24'h000000, PRED, 24'h0));
    // unknown codes give no bytes
    dir_table.push_back(row(4'd9, 1, 1, 1, 1, 0, 24'h0, 0, 24'h0));
    dir_table.push_back(row(4'd15, 255, 255, 255, 255, -1, 24'hFFFFFF, 0, 24'h0));

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_table[i]) begin
      r = dir_table[i];
      send_word(r.word);
      if (r.use_pred) begin
        frame_command(r.word);
      end else begin
        for (int j = 0; j < r.n; j++) begin
          wb.out_byte = 8'(r.bytes >> (8 * (r.n - 1 - j)));
          wb.last     = (j == r.n - 1);
          wire_bytes_q.push_back(wb);
        end
      end
    end
    drain_expected();

    // random words under the three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 55 : 0;
      recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 32 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        cmd_word_t w;
        w = rand_word();
        send_word(w);
        frame_command(w);
      end
      drain_expected();
    end

    // tail: catch any stray byte
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** midi_message_framer_core: PASSED **");
    end else begin
      $display("** midi_message_framer_core: FAILED **");
    end
    $finish;
  end

endmodule
